// File: hw/rtl/fcr_pkg.sv
`default_nettype none

package fcr_pkg;

    // Frame framing bytes
    localparam logic [7:0] START_BYTE = 8'h2A;  // '*'
    localparam logic [7:0] HDR0_BYTE  = 8'h44;  // 'D'
    localparam logic [7:0] HDR1_BYTE  = 8'h52;  // 'R'

    // Frame positions, counted from the byte after the start byte
    localparam logic [3:0] HDR0_POS       = 4'd0;
    localparam logic [3:0] HDR1_POS       = 4'd1;
    localparam logic [3:0] FIRST_DATA_POS = 4'd5;
    localparam logic [3:0] LAST_DATA_POS  = 4'd8;

    localparam logic [7:0]  TIMEOUT_LIMIT_RESET = 8'd150;
    localparam logic [31:0] DEFAULT_WORD_RESET  = 32'h0000_0000;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_COMMIT  = 2'd1,
        EV_HEADER  = 2'd2,
        EV_TIMEOUT = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        CFG_DEFAULT_WORD  = 2'd0,
        CFG_TIMEOUT_LIMIT = 2'd1,
        CFG_UNUSED_2      = 2'd2,
        CFG_UNUSED_3      = 2'd3
    } cfg_index_t;

endpackage

`default_nettype wire

// File: hw/rtl/framed_command_receiver.sv
`default_nettype none

// Framed command receiver. Each input beat is either a received serial byte
// (op = 0) or a timer overflow tick (op = 1). Frames start with '*', followed
// by header "DR" plus three unchecked header bytes and then four data
// bytes at frame positions 5 to 8 that commit as control_word, position 5 in
// bits 7:0. A header mismatch drops the frame; a '*' inside a frame is plain
// data. Every accepted input beat yields exactly one output beat carrying the
// control word after that beat and an event code (none, commit, header error,
// timeout). Ticks count up since the last commit or timeout; once the count
// passes timeout_limit the word reloads default_word and the count clears.
// Throughput is one beat per clock: the whole frame and timeout update is a
// single registered step, and a one-entry output register holds the result,
// so in_ready stays high while that register is empty or being drained.
// out_valid rises in the cycle after an input is accepted. Configuration writes
// (index 0 default_word, 1 timeout_limit) are always accepted and are meant
// to be issued only while no result is outstanding.
module framed_command_receiver
    import fcr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic [7:0]  rx_byte,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      control_word,
    output logic [1:0]       event_res,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    // Configuration registers
    logic [31:0] default_word_reg;
    logic [7:0]  timeout_limit_reg;

    // Receiver state
    logic        in_frame_reg,      in_frame_next;
    logic [3:0]  byte_pos_reg,      byte_pos_next;
    logic [23:0] capture_hold_reg,  capture_hold_next;
    logic [31:0] word_reg,          word_next;
    logic [7:0]  tick_count_reg,    tick_count_next;

    // Output beat register
    logic        out_valid_reg,     out_valid_next;
    event_t      event_res_reg,     event_res_next;

    logic        in_fire;
    logic [7:0]  tick_inc;
    logic [1:0]  data_slot;

    // Accept a new beat whenever the result register is empty or draining.
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign tick_inc  = tick_count_reg + 8'd1;
    assign data_slot = byte_pos_reg[1:0] - FIRST_DATA_POS[1:0];

    // ------------------------------------------------------------------
    // Configuration writes; unknown indexes are dropped.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_word_reg  <= DEFAULT_WORD_RESET;
            timeout_limit_reg <= TIMEOUT_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DEFAULT_WORD:  default_word_reg  <= cfg_data;
                CFG_TIMEOUT_LIMIT: timeout_limit_reg <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Per-beat update of frame and timeout state.
    // ------------------------------------------------------------------
    always_comb
    begin
        in_frame_next     = in_frame_reg;
        byte_pos_next     = byte_pos_reg;
        capture_hold_next = capture_hold_reg;
        word_next         = word_reg;
        tick_count_next   = tick_count_reg;
        event_res_next    = EV_NONE;

        if (in_fire)
        begin
            if (op_t'(op) == OP_TICK)
            begin
                // Advance the tick count; on overrun reload the default word.
                if (tick_inc > timeout_limit_reg)
                begin
                    tick_count_next = 8'd0;
                    word_next       = default_word_reg;
                    event_res_next  = EV_TIMEOUT;
                end
                else
                begin
                    tick_count_next = tick_inc;
                end
            end
            else if (!in_frame_reg)
            begin
                // Hunt for the start byte; drop anything else.
                if (rx_byte == START_BYTE)
                begin
                    in_frame_next = 1'b1;
                    byte_pos_next = 4'd0;
                end
            end
            else
            begin
                byte_pos_next = byte_pos_reg + 4'd1;
                priority if (byte_pos_reg == HDR0_POS)
                begin
                    if (rx_byte != HDR0_BYTE)
                    begin
                        in_frame_next  = 1'b0;
                        event_res_next = EV_HEADER;
                    end
                end
                else if (byte_pos_reg == HDR1_POS)
                begin
                    if (rx_byte != HDR1_BYTE)
                    begin
                        in_frame_next  = 1'b0;
                        event_res_next = EV_HEADER;
                    end
                end
                else if (byte_pos_reg >= FIRST_DATA_POS && byte_pos_reg < LAST_DATA_POS)
                begin
                    // Hold the lower three data bytes until the last one arrives.
                    unique case (data_slot)
                        2'd0:    capture_hold_next[7:0]   = rx_byte;
                        2'd1:    capture_hold_next[15:8]  = rx_byte;
                        2'd2:    capture_hold_next[23:16] = rx_byte;
                        default: ;
                    endcase
                end
                else if (byte_pos_reg == LAST_DATA_POS)
                begin
                    word_next       = {rx_byte, capture_hold_reg};
                    in_frame_next   = 1'b0;
                    tick_count_next = 8'd0;
                    event_res_next  = EV_COMMIT;
                end
                else
                begin
                    // Unchecked header/data positions: drop the byte.
                end
            end
        end
    end

    always_comb
    begin
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            byte_pos_reg   <= 4'd0;
            word_reg       <= 32'd0;
            tick_count_reg <= 8'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            byte_pos_reg   <= byte_pos_next;
            word_reg       <= word_next;
            tick_count_reg <= tick_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        capture_hold_reg <= capture_hold_next;
        if (in_fire)
        begin
            event_res_reg <= event_res_next;
        end
    end

    // The control word only moves on an accepted beat, which is also when the
    // result register loads, so it doubles as the output payload.
    assign out_valid    = out_valid_reg;
    assign control_word = word_reg;
    assign event_res    = event_res_reg;

`ifndef SYNTH
    // A frame never runs past its last data byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (byte_pos_reg <= LAST_DATA_POS))
        else $error("frame position ran past last data byte");

    // Commit and timeout both leave the tick count cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (event_res_reg == EV_COMMIT || event_res_reg == EV_TIMEOUT))
            |-> (tick_count_reg == 8'd0))
        else $error("tick count not cleared after commit or timeout");

    // Commit and header error both end the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (event_res_reg == EV_COMMIT || event_res_reg == EV_HEADER))
            |-> !in_frame_reg)
        else $error("frame still open after commit or header error");

    // Without an accepted beat the receiver state holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> ($stable(word_reg) && $stable(in_frame_reg) && $stable(tick_count_reg)))
        else $error("receiver state moved without an accepted beat");
`endif

endmodule

`default_nettype wire
